FILE: design/srtc_pkg.sv
// ----------------------------------------------------------------------------
// srtc_pkg
// Shared constants, types and helpers for the serial RTC bit interface.
// ----------------------------------------------------------------------------
package srtc_pkg;

  localparam int RAM_BYTES_DEF = 10;

  localparam int ADDR_W = 4;
  localparam int PHASE_W = 4;
  localparam int SLOT_COUNT = 8;
  localparam int IDX_W = $clog2(SLOT_COUNT);

  localparam logic [ADDR_W-1:0] ADDR_CTRL = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_STATUS = 4'h1;
  localparam logic [ADDR_W-1:0] ADDR_FIRST_SLOT = 4'h2;
  localparam logic [ADDR_W-1:0] ADDR_ABORT = 4'hE;
  localparam logic [ADDR_W-1:0] ADDR_LATCH = 4'hF;

  localparam logic [PHASE_W-1:0] PHASE_DATA = 4'd4;
  localparam logic [PHASE_W-1:0] PHASE_END = 4'd12;

  localparam logic [7:0] RAM_RESET_VALUE = 8'hFF;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } rtc_op_t;

  // One access to the clock RAM: a write port and a read port per cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Binary to BCD for values below 100 (up to 127 the tens nibble exceeds 9); tens come from a reciprocal multiply.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  units;
    prod     = {8'b0, v} * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'({3'b0, tens} << 3) + 7'({3'b0, tens} << 1);
    units    = 4'(v - tens_x10);
    return {tens, units};
  endfunction

endpackage

FILE: design/srtc_ram.sv
// ----------------------------------------------------------------------------
// srtc_ram
// Clock RAM with one write and one registered read per cycle. Per-byte valid
// bits make every byte read as 0xFF until it is first written after reset.
// ----------------------------------------------------------------------------
module srtc_ram
  import srtc_pkg::*;
#(
  parameter int RAM_BYTES = RAM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  ram_req_t   req,
  output logic [7:0] rdata
);

  localparam int AW = $clog2(RAM_BYTES);

  logic [7:0]           mem [RAM_BYTES];
  logic [RAM_BYTES-1:0] vld;
  logic [7:0]           q;
  logic                 q_vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      q <= mem[req.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr[AW-1:0]] <= 1'b1;
      end
      if (req.re) begin
        q_vld <= vld[req.raddr[AW-1:0]];
      end
    end
  end

  assign rdata = q_vld ? q : RAM_RESET_VALUE;

endmodule

FILE: design/serial_rtc_bit_interface.sv
// ----------------------------------------------------------------------------
// serial_rtc_bit_interface
// Bit-serial RTC chip interface: address bits, data bits, time latch to BCD.
// ----------------------------------------------------------------------------
// Sequencing: most bit accesses give done in the cycle after start; a read of the
//   first data bit passes through S_RD for the clock RAM read; a latch command
//   walks S_LREQ and S_LCMP for each of the eight time bytes, then S_LFIN writes status.
// Throughput: one word per cycle for plain accesses; busy holds off start
//   during the RAM read and the latch walk. done cannot be stalled.
// Reset: synchronous rst clears phase, address and shift register; RAM reads 0xFF until written.
module serial_rtc_bit_interface
  import srtc_pkg::*;
#(
  parameter int RAM_BYTES = RAM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       op,
  input  logic       data_bit,
  input  logic [5:0] seconds,
  input  logic [5:0] minutes,
  input  logic [4:0] hours,
  input  logic [4:0] day_of_month,
  input  logic [3:0] month,
  input  logic [6:0] year_in_century,
  input  logic [2:0] weekday,
  output logic       done,
  output logic       read_bit
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_LREQ = 5'b00100,
    S_LCMP = 5'b01000,
    S_LFIN = 5'b10000
  } state_t;

  localparam logic [ADDR_W-1:0] RAM_TOP = ADDR_W'(RAM_BYTES);

  state_t             state, state_next;
  logic [PHASE_W-1:0] bit_phase, bit_phase_next;
  logic [ADDR_W-1:0]  reg_address, reg_address_next;
  logic [7:0]         shift_value, shift_value_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [7:0]         mask, mask_next;
  logic               done_next;
  logic               read_bit_next;

  logic [5:0] sec_q, min_q;
  logic [4:0] hrs_q, dom_q;
  logic [3:0] mon_q;
  logic [6:0] yr_q;
  logic [2:0] wd_q;
  logic       capture;

  ram_req_t   req;
  logic [7:0] rdata;

  logic               accept;
  logic [PHASE_W-1:0] phase_inc;
  logic [ADDR_W-1:0]  addr_shift;
  logic [7:0]         data_shift;
  logic [7:0]         load_byte;
  logic [7:0]         slot;
  logic [ADDR_W-1:0]  slot_addr;

  srtc_ram #(
    .RAM_BYTES(RAM_BYTES)
  ) u_ram (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rdata(rdata)
  );

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign phase_inc  = bit_phase + 4'd1;
  assign addr_shift = {data_bit, reg_address[ADDR_W-1:1]};
  assign data_shift = {data_bit, shift_value[7:1]};
  assign load_byte  = (reg_address < RAM_TOP) ? rdata : 8'h00;
  assign slot_addr  = ADDR_FIRST_SLOT + ADDR_W'(idx);

  // Time byte for the slot under the latch walk.
  always_comb begin
    case (idx)
      3'd0:    slot = to_bcd({1'b0, sec_q});
      3'd1:    slot = to_bcd({1'b0, min_q});
      3'd2:    slot = to_bcd({2'b0, hrs_q});
      3'd3:    slot = to_bcd({2'b0, dom_q});
      3'd4:    slot = to_bcd({3'b0, mon_q});
      3'd5:    slot = to_bcd(yr_q);
      3'd6:    slot = {5'b0, wd_q};
      default: slot = to_bcd({2'b0, dom_q});
    endcase
  end

  always_comb begin
    state_next       = state;
    bit_phase_next   = bit_phase;
    reg_address_next = reg_address;
    shift_value_next = shift_value;
    idx_next         = idx;
    mask_next        = mask;
    done_next        = 1'b0;
    read_bit_next    = 1'b0;
    capture          = 1'b0;
    req.we           = 1'b0;
    req.waddr        = reg_address;
    req.wdata        = shift_value;
    req.re           = 1'b0;
    req.raddr        = reg_address;

    case (state)
      S_IDLE: begin
        req.re = accept;
        if (accept) begin
          if (op == OP_READ) begin
            if (bit_phase < PHASE_DATA) begin
              // early read: drop back to the first address bit
              bit_phase_next = '0;
              done_next      = 1'b1;
            end else if (bit_phase == PHASE_DATA) begin
              state_next = S_RD;
            end else begin
              read_bit_next    = shift_value[0];
              shift_value_next = {1'b0, shift_value[7:1]};
              bit_phase_next   = (phase_inc == PHASE_END) ? '0 : phase_inc;
              done_next        = 1'b1;
            end
          end else if (bit_phase < PHASE_DATA) begin
            reg_address_next = addr_shift;
            bit_phase_next   = phase_inc;
            done_next        = 1'b1;
            if (phase_inc == PHASE_DATA && addr_shift >= ADDR_ABORT) begin
              bit_phase_next = '0;
              if (addr_shift == ADDR_LATCH) begin
                // clear the control byte now, status byte at the end
                done_next  = 1'b0;
                capture    = 1'b1;
                req.we     = 1'b1;
                req.waddr  = ADDR_CTRL;
                req.wdata  = 8'h00;
                idx_next   = '0;
                mask_next  = '0;
                state_next = S_LREQ;
              end
            end
          end else begin
            shift_value_next = data_shift;
            bit_phase_next   = phase_inc;
            done_next        = 1'b1;
            if (phase_inc == PHASE_END) begin
              req.we           = (reg_address != ADDR_STATUS) && (reg_address < RAM_TOP);
              req.waddr        = reg_address;
              req.wdata        = data_shift;
              reg_address_next = '0;
              bit_phase_next   = '0;
            end
          end
        end
      end
      S_RD: begin
        read_bit_next    = load_byte[0];
        shift_value_next = {1'b0, load_byte[7:1]};
        bit_phase_next   = PHASE_DATA + 4'd1;
        done_next        = 1'b1;
        state_next       = S_IDLE;
      end
      S_LREQ: begin
        req.re     = 1'b1;
        req.raddr  = slot_addr;
        state_next = S_LCMP;
      end
      S_LCMP: begin
        if (rdata != slot) begin
          req.we         = 1'b1;
          req.waddr      = slot_addr;
          req.wdata      = slot;
          mask_next[idx] = 1'b1;
        end
        if (idx == IDX_W'(SLOT_COUNT - 1)) begin
          state_next = S_LFIN;
        end else begin
          idx_next   = idx + 3'd1;
          state_next = S_LREQ;
        end
      end
      S_LFIN: begin
        req.we     = 1'b1;
        req.waddr  = ADDR_STATUS;
        req.wdata  = mask;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bit_phase   <= '0;
      reg_address <= '0;
      shift_value <= '0;
      done        <= 1'b0;
      read_bit    <= 1'b0;
    end else begin
      state       <= state_next;
      bit_phase   <= bit_phase_next;
      reg_address <= reg_address_next;
      shift_value <= shift_value_next;
      done        <= done_next;
      read_bit    <= read_bit_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    mask <= mask_next;
    if (capture) begin
      sec_q <= seconds;
      min_q <= minutes;
      hrs_q <= hours;
      dom_q <= day_of_month;
      mon_q <= month;
      yr_q  <= year_in_century;
      wd_q  <= weekday;
    end
  end

endmodule

FILE: design/srtc_checker.sv
// ----------------------------------------------------------------------------
// srtc_checker
// Port-level checks on the serial RTC bit interface, bound to the top level.
// ----------------------------------------------------------------------------
module srtc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic read_bit
);

  // a result never shows while the block is still working
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  a_bit_strobed: assert property (@(posedge clk) disable iff (rst) read_bit |-> done)
    else $error("read_bit high without done");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted word left no trace");

  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without an accepted word");

endmodule

bind serial_rtc_bit_interface srtc_checker u_srtc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .read_bit(read_bit)
);

FILE: bench/srtc_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srtc_tb_pkg
// Time-of-day bundle shared by the bench and its checker.
// ----------------------------------------------------------------------------
package srtc_tb_pkg;

  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [6:0] year_in_century;
    logic [2:0] weekday;
  } rtc_time_t;

endpackage

FILE: bench/serial_rtc_bit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_rtc_bit_checker
// Watches the bit access channel, mirrors the address/data shifter and the
// clock RAM, and compares read_bit with the predicted bit on every done.
// ----------------------------------------------------------------------------
module serial_rtc_bit_checker
  import srtc_pkg::*;
  import srtc_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic       op,
  input  logic       data_bit,
  input  logic [5:0] seconds,
  input  logic [5:0] minutes,
  input  logic [4:0] hours,
  input  logic [4:0] day_of_month,
  input  logic [3:0] month,
  input  logic [6:0] year_in_century,
  input  logic [2:0] weekday,
  input  logic       done,
  input  logic       read_bit,
  output int         fail_count,
  output int         pending_words
);

  localparam logic [ADDR_W-1:0] RAM_TOP = ADDR_W'(RAM_BYTES_DEF);

  logic [7:0]         ram_img [RAM_BYTES_DEF];
  logic [PHASE_W-1:0] phase_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [7:0]         shift_q;
  logic               read_bits_due [$];
  int                 mismatches;

  function automatic logic [7:0] bin2bcd(input int unsigned v);
    return 8'(((v / 10) << 4) + (v % 10));
  endfunction

  task automatic latch_clock(input rtc_time_t t);
    logic [7:0] slot [SLOT_COUNT];
    int         idx;
    slot[0] = bin2bcd(int'(t.seconds));
    slot[1] = bin2bcd(int'(t.minutes));
    slot[2] = bin2bcd(int'(t.hours));
    slot[3] = bin2bcd(int'(t.day_of_month));
    slot[4] = bin2bcd(int'(t.month));
    slot[5] = bin2bcd(int'(t.year_in_century));
    slot[6] = {5'b0, t.weekday};
    slot[7] = bin2bcd(int'(t.day_of_month));
    ram_img[ADDR_CTRL]   = 8'h00;
    ram_img[ADDR_STATUS] = 8'h00;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      idx = int'(ADDR_FIRST_SLOT) + i;
      // flag each time byte that actually changes
      if (ram_img[idx] != slot[i]) begin
        ram_img[idx] = slot[i];
        ram_img[ADDR_STATUS][i] = 1'b1;
      end
    end
  endtask

  task automatic shift_rtc_bit(input logic is_read, input logic wbit, input rtc_time_t t,
                               output logic rbit);
    rbit = 1'b0;
    if (is_read) begin
      if (phase_q < PHASE_DATA) begin
        phase_q = '0;
      end else begin
        if (phase_q == PHASE_DATA)
          shift_q = (addr_q < RAM_TOP) ? ram_img[addr_q] : 8'h00;
        phase_q = (phase_q + 4'd1 >= PHASE_END) ? '0 : phase_q + 4'd1;
        rbit    = shift_q[0];
        shift_q = shift_q >> 1;
      end
    end else if (phase_q < PHASE_DATA) begin
      addr_q  = {wbit, addr_q[ADDR_W-1:1]};
      phase_q = phase_q + 4'd1;
      if (phase_q == PHASE_DATA && addr_q >= ADDR_ABORT) begin
        if (addr_q == ADDR_LATCH)
          latch_clock(t);
        phase_q = '0;
      end
    end else begin
      shift_q = {wbit, shift_q[7:1]};
      phase_q = phase_q + 4'd1;
      if (phase_q >= PHASE_END) begin
        // status byte and the upper addresses are read only
        if (addr_q != ADDR_STATUS && addr_q < RAM_TOP)
          ram_img[addr_q] = shift_q;
        addr_q  = '0;
        phase_q = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    rtc_time_t now;
    logic      due;
    if (rst) begin
      foreach (ram_img[i]) ram_img[i] = RAM_RESET_VALUE;
      phase_q    = '0;
      addr_q     = '0;
      shift_q    = '0;
      mismatches = 0;
      read_bits_due.delete();
    end else begin
      // compare before pushing: a word accepted now answers on a later edge
      if (done) begin
        if (read_bits_due.size() == 0) begin
          $display("%0t: done with no word outstanding, expected none, actual read_bit %0b",
                   $time, read_bit);
          mismatches++;
        end else begin
          due = read_bits_due.pop_front();
          if (read_bit !== due) begin
            $display("%0t: read_bit mismatch, expected %0b, actual %0b", $time, due, read_bit);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        now = '{seconds, minutes, hours, day_of_month, month, year_in_century, weekday};
        shift_rtc_bit(op == OP_READ, data_bit, now, due);
        read_bits_due.push_back(due);
      end
    end
    fail_count    <= mismatches;
    pending_words <= read_bits_due.size();
  end

endmodule

FILE: bench/serial_rtc_bit_interface_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_rtc_bit_interface_tb
// Drives bit accesses in bursts: directed latch and status reads, then random
// address, read, write, latch, abort, mixed and noise sequences.
// ----------------------------------------------------------------------------
module serial_rtc_bit_interface_tb;
  import srtc_pkg::*;
  import srtc_tb_pkg::*;

  localparam int RANDOM_WORDS = 1600;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      op;
  logic      data_bit;
  rtc_time_t time_in;
  logic      done;
  logic      read_bit;
  int        fail_count;
  int        pending_words;

  rtc_time_t latch_now;
  int        words_sent;
  int        burst_left;

  serial_rtc_bit_interface u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .data_bit        (data_bit),
    .seconds         (time_in.seconds),
    .minutes         (time_in.minutes),
    .hours           (time_in.hours),
    .day_of_month    (time_in.day_of_month),
    .month           (time_in.month),
    .year_in_century (time_in.year_in_century),
    .weekday         (time_in.weekday),
    .done            (done),
    .read_bit        (read_bit)
  );

  serial_rtc_bit_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .data_bit        (data_bit),
    .seconds         (time_in.seconds),
    .minutes         (time_in.minutes),
    .hours           (time_in.hours),
    .day_of_month    (time_in.day_of_month),
    .month           (time_in.month),
    .year_in_century (time_in.year_in_century),
    .weekday         (time_in.weekday),
    .done            (done),
    .read_bit        (read_bit),
    .fail_count      (fail_count),
    .pending_words   (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic rtc_time_t random_time(input logic full_width);
    rtc_time_t t;
    if (full_width) begin
      t.seconds         = 6'($urandom);
      t.minutes         = 6'($urandom);
      t.hours           = 5'($urandom);
      t.day_of_month    = 5'($urandom);
      t.month           = 4'($urandom);
      t.year_in_century = 7'($urandom);
      t.weekday         = 3'($urandom);
    end else begin
      t.seconds         = 6'($urandom_range(0, 59));
      t.minutes         = 6'($urandom_range(0, 59));
      t.hours           = 5'($urandom_range(0, 23));
      t.day_of_month    = 5'($urandom_range(1, 31));
      t.month           = 4'($urandom_range(1, 12));
      t.year_in_century = 7'($urandom_range(0, 99));
      t.weekday         = 3'($urandom_range(0, 6));
    end
    return t;
  endfunction

  // Call at a rising edge; returns after acceptance and any burst gap.
  task automatic send_word(input rtc_op_t o, input logic b, input logic hold_time);
    start    <= 1'b1;
    op       <= o;
    data_bit <= b;
    time_in  <= hold_time ? latch_now : random_time($urandom_range(0, 3) == 0);
    do @(posedge clk); while (busy);
    words_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_address(input logic [ADDR_W-1:0] addr, input logic hold_time);
    for (int i = 0; i < ADDR_W; i++)
      send_word(OP_WRITE, addr[i], hold_time);
  endtask

  task automatic read_byte(input logic [ADDR_W-1:0] addr);
    send_address(addr, 1'b0);
    repeat (8) send_word(OP_READ, 1'($urandom), 1'b0);
  endtask

  task automatic latch_time(input rtc_time_t t);
    latch_now = t;
    send_address(ADDR_LATCH, 1'b1);
  endtask

  // Hold off until every accepted word has answered.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  initial begin
    int           kind;
    logic [ADDR_W-1:0] addr;
    rtc_time_t    t;
    rst        <= 1'b1;
    start      <= 1'b0;
    op         <= OP_WRITE;
    data_bit   <= 1'b0;
    time_in    <= '0;
    words_sent = 0;
    burst_left = 4;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // read before any address bit: returns 0
    send_word(OP_READ, 1'b1, 1'b0);
    // latch with every field at full width, then read back the change flags
    latch_time('1);
    read_byte(ADDR_STATUS);
    t = '{6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 7'd99, 3'd6};
    latch_time(t);
    t = '{6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 7'd0, 3'd0};
    latch_time(t);
    drain_results();

    while (words_sent < RANDOM_WORDS + 25) begin
      kind = $urandom_range(0, 99);
      addr = 4'($urandom_range(0, 13));
      if (kind < 12) begin
        // reuse the last time now and then so some bytes stay unchanged
        if ($urandom_range(0, 2) != 0)
          latch_now = random_time($urandom_range(0, 3) == 0);
        send_address(ADDR_LATCH, 1'b1);
      end else if (kind < 40) begin
        send_address(addr, 1'b0);
        repeat (8) send_word(OP_WRITE, 1'($urandom), 1'b0);
      end else if (kind < 70) begin
        read_byte(addr);
      end else if (kind < 75) begin
        send_address(ADDR_ABORT, 1'b0);
      end else if (kind < 88) begin
        send_address(addr, 1'b0);
        repeat (8) send_word(rtc_op_t'($urandom_range(0, 1)), 1'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(rtc_op_t'($urandom_range(0, 1)), 1'($urandom), 1'b0);
        // nine reads bring the phase back to zero from anywhere
        repeat (9) send_word(OP_READ, 1'($urandom), 1'b0);
      end
      if ($urandom_range(0, 24) == 0)
        drain_results();
    end

    drain_results();
    repeat (24) @(posedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
